// File: rtl/rbd_pkg.sv
// Shared types and constants of the region border detector.
package rbd_pkg;

  // Fixed field widths of the channels and the configuration port.
  localparam int ACTION_W   = 1;
  localparam int REGION_W   = 16;
  localparam int CELL_X_W   = 10;
  localparam int CELL_Z_W   = 16;
  localparam int ROW_W      = 16;
  localparam int GRID_W_W   = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Input beat opcode.
  typedef enum logic [ACTION_W-1:0] {
    ACT_CELL  = 1'b0,
    ACT_FLUSH = 1'b1
  } action_t;

  // Configuration register index.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH = 1'b0,
    CFG_GRID_DEPTH = 1'b1
  } cfg_reg_t;

  // What an accepted beat turns into.
  typedef enum logic [1:0] {
    ITEM_NOP,
    ITEM_CELL,
    ITEM_FLUSH
  } item_kind_t;

  // Per-beat control from the sequencer to the evaluation stage.
  typedef struct packed {
    item_kind_t             kind;
    logic                   has_up;  // cell has a row above (emits a result)
    logic [ROW_W-1:0]       row;     // row reported in the result
    logic                   last;    // final cell of the grid
  } rbd_ctrl_t;

  // Line store write enables.
  typedef struct packed {
    logic ra;        // label of the current column
    logic pf_own;    // partial flag of the current column
    logic pf_left;   // set partial flag of the column to the left
  } rbd_wen_t;

endpackage

// File: rtl/rbd_if.sv
// Valid/ready channel interfaces for cell beats and result beats.
interface rbd_in_if;
  import rbd_pkg::*;
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [REGION_W-1:0] region;

  modport source (output valid, output action, output region, input ready);
  modport sink   (input valid, input action, input region, output ready);
endinterface

interface rbd_out_if;
  import rbd_pkg::*;
  logic                valid;
  logic                ready;
  logic                border;
  logic [CELL_X_W-1:0] cell_x;
  logic [CELL_Z_W-1:0] cell_z;
  logic                last;

  modport source (output valid, output border, output cell_x, output cell_z, output last,
                  input ready);
  modport sink   (input valid, input border, input cell_x, input cell_z, input last,
                  output ready);
endinterface

// File: rtl/rbd_seq.sv
// Grid sequencer: configuration, column/row/drain counters and beat classification.
module rbd_seq #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [rbd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rbd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_accept,
  input  logic [rbd_pkg::ACTION_W-1:0]     in_action,
  output rbd_pkg::rbd_ctrl_t               ctrl,
  output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] cur_x
);
  import rbd_pkg::*;

  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [XW-1:0]       w_last_r, w_last_nxt;
  logic [ROW_W-1:0]    d_last_r, d_last_nxt;
  logic [XW-1:0]       col_r, col_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [XW-1:0]       drn_r, drn_nxt;
  logic [GRID_W_W-1:0] cfg_w;
  logic                draining;
  logic                col_last;
  logic                drn_last;

  assign cfg_w    = cfg_data[GRID_W_W-1:0];
  assign draining = row_r > d_last_r;
  assign col_last = col_r == w_last_r;
  assign drn_last = drn_r == w_last_r;

  // classify the beat presented on the input
  always_comb begin
    ctrl.kind   = ITEM_NOP;
    ctrl.has_up = row_r != '0;
    ctrl.row    = row_r - ROW_W'(1);
    ctrl.last   = 1'b0;
    cur_x       = col_r;
    if (in_action == ACT_FLUSH) begin
      cur_x       = drn_r;
      ctrl.has_up = 1'b0;
      ctrl.row    = d_last_r;
      ctrl.last   = drn_last;
      if (draining) begin
        ctrl.kind = ITEM_FLUSH;
      end
    end else if (!draining) begin
      ctrl.kind = ITEM_CELL;
    end
  end

  always_comb begin
    w_last_nxt = w_last_r;
    d_last_nxt = d_last_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    drn_nxt    = drn_r;
    if (cfg_we) begin
      // any register write abandons the grid in progress
      col_nxt = '0;
      row_nxt = '0;
      drn_nxt = '0;
      unique case (cfg_reg_t'(cfg_index))
        CFG_GRID_WIDTH: begin
          if (cfg_w == '0) begin
            w_last_nxt = '0;
          end else if (32'(cfg_w) > 32'(MAX_WIDTH)) begin
            w_last_nxt = XW'(MAX_WIDTH - 1);
          end else begin
            w_last_nxt = XW'(cfg_w - GRID_W_W'(1));
          end
        end
        CFG_GRID_DEPTH: begin
          d_last_nxt = (cfg_data == '0) ? '0 : cfg_data - ROW_W'(1);
        end
      endcase
    end else if (in_accept) begin
      case (ctrl.kind)
        ITEM_CELL: begin
          if (col_last) begin
            col_nxt = '0;
            row_nxt = row_r + ROW_W'(1);
          end else begin
            col_nxt = col_r + XW'(1);
          end
        end
        ITEM_FLUSH: begin
          if (drn_last) begin
            col_nxt = '0;
            row_nxt = '0;
            drn_nxt = '0;
          end else begin
            drn_nxt = drn_r + XW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_last_r <= '0;
      d_last_r <= '0;
      col_r    <= '0;
      row_r    <= '0;
      drn_r    <= '0;
    end else begin
      w_last_r <= w_last_nxt;
      d_last_r <= d_last_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      drn_r    <= drn_nxt;
    end
  end

  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= w_last_r)
    else $error("column counter beyond row width");

  a_drain_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    drn_r != '0 |-> draining)
    else $error("drain counter moved outside the drain");

  a_drain_col_zero: assert property (@(posedge clk) disable iff (!rst_n)
    draining |-> col_r == '0)
    else $error("column counter not cleared during drain");

endmodule

// File: rtl/rbd_line_store.sv
// Line store: previous-row labels and two parity banks of partial border flags.
module rbd_line_store #(
  parameter int MAX_WIDTH  = 1024,
  parameter int LABEL_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] rd_x,
  input  rbd_pkg::rbd_wen_t     wen,
  input  logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] wr_x,
  input  logic [LABEL_BITS-1:0] wr_lab,
  input  logic                  wr_flag,
  output logic [LABEL_BITS-1:0] ra_q,
  output logic                  pf_q
);
  import rbd_pkg::*;

  localparam int XW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int BD  = (MAX_WIDTH + 1) / 2;
  localparam int BIW = (BD > 1) ? $clog2(BD) : 1;

  logic [LABEL_BITS-1:0] ra_mem [MAX_WIDTH];
  logic                  ev_mem [BD];
  logic                  od_mem [BD];

  logic [XW-1:0]         xl;
  logic                  own_odd;
  logic                  ev_we, od_we;
  logic [BIW-1:0]        ev_idx, od_idx, rd_bi;
  logic                  ev_d, od_d;

  logic [LABEL_BITS-1:0] ra_q_r, ra_byp_r;
  logic                  ra_hit_r;
  logic                  ev_q_r, ev_byp_r, ev_hit_r;
  logic                  od_q_r, od_byp_r, od_hit_r;
  logic                  par_r;

  function automatic logic [BIW-1:0] bank_idx(input logic [XW-1:0] x);
    return BIW'(x >> 1);
  endfunction

  // own column and left column always sit in opposite banks
  assign xl      = wr_x - XW'(1);
  assign own_odd = wr_x[0];
  assign rd_bi   = bank_idx(rd_x);

  always_comb begin
    ev_we  = 1'b0;
    ev_idx = bank_idx(wr_x);
    ev_d   = wr_flag;
    od_we  = 1'b0;
    od_idx = bank_idx(wr_x);
    od_d   = wr_flag;
    if (wen.pf_own) begin
      if (own_odd) begin
        od_we = 1'b1;
      end else begin
        ev_we = 1'b1;
      end
    end
    if (wen.pf_left) begin
      if (own_odd) begin
        ev_we  = 1'b1;
        ev_idx = bank_idx(xl);
        ev_d   = 1'b1;
      end else begin
        od_we  = 1'b1;
        od_idx = bank_idx(xl);
        od_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wen.ra) begin
      ra_mem[wr_x] <= wr_lab;
    end
    if (ev_we) begin
      ev_mem[ev_idx] <= ev_d;
    end
    if (od_we) begin
      od_mem[od_idx] <= od_d;
    end
  end

  // registered reads; a write landing at the same edge is forwarded
  always_ff @(posedge clk) begin
    if (rd_en) begin
      ra_q_r   <= ra_mem[rd_x];
      ev_q_r   <= ev_mem[rd_bi];
      od_q_r   <= od_mem[rd_bi];
      par_r    <= rd_x[0];
      ra_hit_r <= wen.ra && (wr_x == rd_x);
      ra_byp_r <= wr_lab;
      ev_hit_r <= ev_we && (ev_idx == rd_bi);
      ev_byp_r <= ev_d;
      od_hit_r <= od_we && (od_idx == rd_bi);
      od_byp_r <= od_d;
    end
  end

  assign ra_q = ra_hit_r ? ra_byp_r : ra_q_r;
  assign pf_q = par_r ? (od_hit_r ? od_byp_r : od_q_r)
                      : (ev_hit_r ? ev_byp_r : ev_q_r);

endmodule

// File: rtl/rbd_eval.sv
// Evaluation stage: neighbor compares, line store updates and the result register.
module rbd_eval #(
  parameter int MAX_WIDTH  = 1024,
  parameter int LABEL_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_accept,
  input  rbd_pkg::rbd_ctrl_t            ctrl_in,
  input  logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] x_in,
  input  logic [LABEL_BITS-1:0]         lab_in,
  input  logic [LABEL_BITS-1:0]         ra_q,
  input  logic                          pf_q,
  output rbd_pkg::rbd_wen_t             wen,
  output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] wr_x,
  output logic [LABEL_BITS-1:0]         wr_lab,
  output logic                          wr_flag,
  output logic                          s1_free,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_border,
  output logic [rbd_pkg::CELL_X_W-1:0]  out_cell_x,
  output logic [rbd_pkg::CELL_Z_W-1:0]  out_cell_z,
  output logic                          out_last
);
  import rbd_pkg::*;

  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic                  s1_v_r;
  rbd_ctrl_t             s1_ctrl_r;
  logic [XW-1:0]         s1_x_r;
  logic [LABEL_BITS-1:0] s1_lab_r;
  logic [LABEL_BITS-1:0] left_r;

  logic                  out_v_r;
  logic                  out_border_r;
  logic [CELL_X_W-1:0]   out_x_r;
  logic [CELL_Z_W-1:0]   out_z_r;
  logic                  out_last_r;

  logic                  is_cell, is_flush;
  logic                  up_diff, left_diff;
  logic                  emit, border, s1_fire;

  assign is_cell   = s1_ctrl_r.kind == ITEM_CELL;
  assign is_flush  = s1_ctrl_r.kind == ITEM_FLUSH;
  assign up_diff   = s1_ctrl_r.has_up && (ra_q != s1_lab_r);
  assign left_diff = (s1_x_r != '0) && (left_r != s1_lab_r);
  assign emit      = is_flush || (is_cell && s1_ctrl_r.has_up);
  // partial flag of the row above plus its down neighbor
  assign border    = pf_q | up_diff;
  assign s1_fire   = s1_v_r && (!emit || !out_v_r || out_ready);
  assign s1_free   = !s1_v_r || s1_fire;

  assign wen.ra      = s1_fire && is_cell;
  assign wen.pf_own  = s1_fire && is_cell;
  assign wen.pf_left = s1_fire && is_cell && left_diff;
  assign wr_x        = s1_x_r;
  assign wr_lab      = s1_lab_r;
  assign wr_flag     = up_diff | left_diff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_accept && ctrl_in.kind != ITEM_NOP) begin
      s1_v_r <= 1'b1;
    end else if (s1_fire) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_ctrl_r <= ctrl_in;
      s1_x_r    <= x_in;
      s1_lab_r  <= lab_in;
    end
    if (s1_fire && is_cell) begin
      left_r <= s1_lab_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_fire && emit) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && emit) begin
      out_border_r <= border;
      out_x_r      <= CELL_X_W'(s1_x_r);
      out_z_r      <= CELL_Z_W'(s1_ctrl_r.row);
      out_last_r   <= s1_ctrl_r.last;
    end
  end

  assign out_valid  = out_v_r;
  assign out_border = out_border_r;
  assign out_cell_x = out_x_r;
  assign out_cell_z = out_z_r;
  assign out_last   = out_last_r;

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s1_fire |-> out_v_r && !out_ready)
    else $error("evaluation stage stalled without a blocked result");

  a_left_not_col0: assert property (@(posedge clk) disable iff (!rst_n)
    wen.pf_left |-> s1_x_r != '0)
    else $error("left flag update at column zero");

endmodule

// File: rtl/region_border_detect_core.sv
// A cell or flush beat passes the evaluation stage before its result is registered.
// One input beat per cycle unless stalled; a cell's result emerges while the next row streams.
// Back-pressure on the result side stalls input only when the result register is still full.
// Reset (rst_n low, synchronous): counters and valid bits cleared, grid 1 x 1.
// The line store is not cleared; every entry is written within a grid before it is read.
module region_border_detect_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int LABEL_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  rbd_in_if.sink                         in_ch,
  rbd_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [rbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rbd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rbd_pkg::*;

  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // Dataflow:
  //   accept edge : sequencer classifies the beat, advances counters and the
  //                 line store reads the column's label and partial flag
  //   evaluation  : compares against the row above and the left neighbor;
  //                 unless stalled, updates the line store, loads the result register
  // A cell in row z completes the result of column x in row z-1, so results
  // trail the input by one row; flush beats drain the last row.

  logic                  in_accept;
  logic                  s1_free;
  logic [LABEL_BITS-1:0] in_label;
  rbd_ctrl_t             ctrl;
  logic [XW-1:0]         cur_x;

  rbd_wen_t              wen;
  logic [XW-1:0]         wr_x;
  logic [LABEL_BITS-1:0] wr_lab;
  logic                  wr_flag;
  logic [LABEL_BITS-1:0] ra_q;
  logic                  pf_q;

  // input beat taken whenever the evaluation stage is empty or moving on
  assign in_ch.ready = s1_free;
  assign in_accept   = in_ch.valid && s1_free;
  // only the low label bits take part in the compare
  assign in_label    = LABEL_BITS'(in_ch.region);

  rbd_seq #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_accept (in_accept),
    .in_action (in_ch.action),
    .ctrl      (ctrl),
    .cur_x     (cur_x)
  );

  rbd_line_store #(
    .MAX_WIDTH  (MAX_WIDTH),
    .LABEL_BITS (LABEL_BITS)
  ) u_store (
    .clk     (clk),
    .rd_en   (in_accept),
    .rd_x    (cur_x),
    .wen     (wen),
    .wr_x    (wr_x),
    .wr_lab  (wr_lab),
    .wr_flag (wr_flag),
    .ra_q    (ra_q),
    .pf_q    (pf_q)
  );

  rbd_eval #(
    .MAX_WIDTH  (MAX_WIDTH),
    .LABEL_BITS (LABEL_BITS)
  ) u_eval (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_accept  (in_accept),
    .ctrl_in    (ctrl),
    .x_in       (cur_x),
    .lab_in     (in_label),
    .ra_q       (ra_q),
    .pf_q       (pf_q),
    .wen        (wen),
    .wr_x       (wr_x),
    .wr_lab     (wr_lab),
    .wr_flag    (wr_flag),
    .s1_free    (s1_free),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_border (out_ch.border),
    .out_cell_x (out_ch.cell_x),
    .out_cell_z (out_ch.cell_z),
    .out_last   (out_ch.last)
  );

endmodule
